FILE: rtl/tlp3_pkg.sv
package tlp3_pkg;

  localparam int TIME_BITS = 16;
  localparam int POS_W     = 32;
  // 5*t doubled needs four bits above the time width
  localparam int NUM_W     = TIME_BITS + 4;
  // three integer quotient bits, then 32 fraction bits
  localparam int INT_STEPS = 3;
  localparam int DIV_STEPS = INT_STEPS + 32;
  localparam int Q_W       = DIV_STEPS;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_MOVE_TIME = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_X   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_Y   = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_Z   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DELTA_X   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DELTA_Y   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DELTA_Z   = 3'd6;

  localparam logic [TIME_BITS-1:0] MOVE_TIME_RST = TIME_BITS'(1000);

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_GOAL   = 2'd3
  } phase_t;

endpackage

FILE: rtl/trapezoid_line_profile_3axis_top.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------
// input     | in_valid / in_ready    | elapsed_ms
// output    | out_valid / out_ready  | pos_x, pos_y, pos_z, phase
// config    | cfg_we (no wait)       | cfg_index, cfg_data
//
// One sample per cycle unless the output stalls. Stages: one decode stage,
// a 35-stage restoring divider by the move time (one quotient bit per stage),
// square, fraction select, per-axis multiply and round/saturate stages.
// Synchronous reset clears the valid bits and restores the register defaults.
// A stall at the output holds every stage; nothing is dropped or repeated.
module trapezoid_line_profile_3axis_top
  import tlp3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_BITS-1:0]    elapsed_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic [1:0]              phase
);

  localparam int NSTG = DIV_STEPS + 5;

  logic [TIME_BITS-1:0]    span_ms;
  logic signed [POS_W-1:0] start_v [3];
  logic signed [POS_W-1:0] delta_v [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      span_ms <= MOVE_TIME_RST;
      for (int a = 0; a < 3; a++) begin
        start_v[a] <= '0;
        delta_v[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_TIME: span_ms    <= cfg_data[TIME_BITS-1:0];
        REG_START_X:   start_v[0] <= cfg_data;
        REG_START_Y:   start_v[1] <= cfg_data;
        REG_START_Z:   start_v[2] <= cfg_data;
        REG_DELTA_X:   delta_v[0] <= cfg_data;
        REG_DELTA_Y:   delta_v[1] <= cfg_data;
        REG_DELTA_Z:   delta_v[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv       = !vld[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // decode: phase and divider numerator
  logic [NUM_W-1:0] t_e, tt_e, u;
  phase_t           ph_in;
  logic [NUM_W-1:0] n_in;

  always_comb begin
    t_e  = NUM_W'(elapsed_ms);
    tt_e = NUM_W'(span_ms);
    u    = (t_e << 2) + t_e;
    n_in = '0;
    if (span_ms == '0) begin
      ph_in = PH_GOAL;
    end else if (u <= tt_e) begin
      ph_in = PH_ACCEL;
      n_in  = u;
    end else if (u <= (tt_e << 2)) begin
      ph_in = PH_CRUISE;
      n_in  = (u << 1) - tt_e;
    end else if (elapsed_ms < span_ms) begin
      ph_in = PH_DECEL;
      n_in  = ((tt_e - t_e) << 2) + (tt_e - t_e);
    end else begin
      ph_in = PH_GOAL;
    end
  end

  // divider line: index 0 is the decode register
  logic [NUM_W-1:0] drem [DIV_STEPS+1];
  logic [Q_W-1:0]   dq   [DIV_STEPS+1];
  phase_t           dph  [DIV_STEPS+1];
  logic [NUM_W-1:0] drem_next [DIV_STEPS];
  logic [Q_W-1:0]   dq_next   [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [NUM_W-1:0] rs, dv;
      if (k < INT_STEPS) begin
        rs = drem[k];
        dv = NUM_W'(span_ms) << (INT_STEPS - 1 - k);
      end else begin
        rs = drem[k] << 1;
        dv = NUM_W'(span_ms);
      end
      if (rs >= dv) begin
        drem_next[k] = rs - dv;
        dq_next[k]   = {dq[k][Q_W-2:0], 1'b1};
      end else begin
        drem_next[k] = rs;
        dq_next[k]   = {dq[k][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drem[0] <= n_in;
      dq[0]   <= '0;
      dph[0]  <= ph_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        drem[k+1] <= drem_next[k];
        dq[k+1]   <= dq_next[k];
        dph[k+1]  <= dph[k];
      end
    end
  end

  // square the ramp ratio, keep the cruise fraction
  logic [Q_W-1:0] qf;
  logic [63:0]    sq;
  logic [31:0]    fcr;
  phase_t         mph;

  assign qf = dq[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq  <= 64'(qf[32:1]) * 64'(qf[32:1]);
      fcr <= qf[34:3];
      mph <= dph[DIV_STEPS];
    end
  end

  // fraction of the move in Q1.32
  logic [64:0] g_sum;
  logic [32:0] g, f_next, f;
  phase_t      fph;

  always_comb begin
    g_sum = 65'(sq) + (65'd1 << 32);
    g     = {1'b0, g_sum[64:33]};
    case (mph)
      PH_ACCEL:  f_next = g;
      PH_DECEL:  f_next = (33'd1 << 32) - g;
      PH_CRUISE: f_next = {1'b0, fcr};
      default:   f_next = 33'd1 << 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f   <= f_next;
      fph <= mph;
    end
  end

  // per-axis magnitude times fraction
  logic [63:0] prod [3];
  logic        pneg [3];
  phase_t      pph;

  always_ff @(posedge clk) begin
    if (adv) begin
      pph <= fph;
      for (int a = 0; a < 3; a++) begin
        logic [31:0] mag;
        mag = delta_v[a][POS_W-1] ? 32'(-delta_v[a]) : 32'(delta_v[a]);
        pneg[a] <= delta_v[a][POS_W-1];
        prod[a] <= f[32] ? {mag, 32'd0} : 64'(mag) * 64'(f[31:0]);
      end
    end
  end

  // round, apply sign, add start, saturate
  logic signed [POS_W-1:0] pos_next [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [64:0]       rsum;
      logic [32:0]       off;
      logic signed [34:0] p;
      rsum = 65'(prod[a]) + (65'd1 << 31);
      off  = rsum[64:32];
      p    = 35'(start_v[a]) + (pneg[a] ? -$signed({2'b0, off}) : $signed({2'b0, off}));
      if (p > 35'sd2147483647) begin
        pos_next[a] = 32'h7FFF_FFFF;
      end else if (p < -35'sd2147483648) begin
        pos_next[a] = 32'h8000_0000;
      end else begin
        pos_next[a] = p[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x <= pos_next[0];
      pos_y <= pos_next[1];
      pos_z <= pos_next[2];
      phase <= pph;
    end
  end

  a_zero_time_goal: assert property (@(posedge clk) disable iff (rst)
    out_valid && span_ms == '0 |-> phase == PH_GOAL)
    else $error("zero move time must report goal");

  a_goal_no_delta: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_GOAL && delta_v[0] == '0 |-> pos_x == start_v[0])
    else $error("goal with zero delta must sit at start");

  a_accel_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase == PH_ACCEL && !delta_v[0][POS_W-1] |-> pos_x >= start_v[0])
    else $error("positive move went backward while accelerating");

endmodule
